FILE: design/ipa_pkg.sv
// ----------------------------------------------------------------------------
// ipa_pkg
// Shared types, codes and helper functions of the IP address text parser.
// ----------------------------------------------------------------------------
package ipa_pkg;

  localparam int GroupCount = 8;
  localparam int GroupWidth = 16;
  localparam int CharWidth  = 8;
  localparam int AddrHalfWidth = 64;

  // Text form codes.
  localparam logic [1:0] FormUndecided = 2'd0;
  localparam logic [1:0] FormDotted    = 2'd1;
  localparam logic [1:0] FormColon     = 2'd2;

  // Separator tracking codes.
  localparam logic [2:0] SepStart      = 3'd0;
  localparam logic [2:0] SepLeadColon  = 3'd1;
  localparam logic [2:0] SepToken      = 3'd2;
  localparam logic [2:0] SepAfterColon = 3'd3;
  localparam logic [2:0] SepAfterGap   = 3'd4;
  localparam logic [2:0] SepAfterDot   = 3'd5;

  localparam logic [16:0] HexMax  = 17'h0FFFF;
  localparam logic [16:0] HexOver = 17'h10000;
  localparam logic [8:0]  DecMax  = 9'h0FF;
  localparam logic [8:0]  DecOver = 9'h100;

  typedef logic [GroupWidth-1:0] group_t;

  typedef struct packed {
    group_t [GroupCount-1:0] groups;
    logic [3:0]  groups_done;
    logic        gap_seen;
    logic [3:0]  gap_position;
    logic [16:0] hex_accum;
    logic [8:0]  dec_accum;
    logic [1:0]  digit_count;
    logic        first_digit_zero;
    logic        hex_letter_seen;
    logic [1:0]  text_form;
    logic [2:0]  octet_index;
    logic [31:0] octet_store;
    logic        in_dotted_tail;
    logic [2:0]  sep_state;
    logic        error_flag;
  } parse_st_t;

  // Closes a decimal octet into the packed IPv4 word.
  function automatic parse_st_t take_octet(parse_st_t s);
    logic ok;
    ok = (s.dec_accum <= DecMax) && !s.hex_letter_seen &&
         !(s.first_digit_zero && (s.digit_count >= 2'd2));
    if (!ok || (s.octet_index > 3'd3)) begin
      s.error_flag = 1'b1;
    end else begin
      case (s.octet_index[1:0])
        2'd0:    s.octet_store[31:24] = s.dec_accum[7:0];
        2'd1:    s.octet_store[23:16] = s.dec_accum[7:0];
        2'd2:    s.octet_store[15:8]  = s.dec_accum[7:0];
        default: s.octet_store[7:0]   = s.dec_accum[7:0];
      endcase
    end
    return s;
  endfunction

  // Closes a hex group into the group store.
  function automatic parse_st_t take_group(parse_st_t s);
    if ((s.groups_done >= 4'(GroupCount)) || (s.hex_accum > HexMax)) begin
      s.error_flag = 1'b1;
    end else begin
      s.groups[s.groups_done[2:0]] = s.hex_accum[15:0];
      s.groups_done = s.groups_done + 4'd1;
    end
    return s;
  endfunction

endpackage

FILE: design/ipa_step.sv
// ----------------------------------------------------------------------------
// ipa_step
// Next-state logic of the parser for one character.
// ----------------------------------------------------------------------------
module ipa_step (
  input  ipa_pkg::parse_st_t st,
  input  logic [7:0]         char_code,
  output ipa_pkg::parse_st_t st_next
);
  import ipa_pkg::*;

  logic        is_dec;
  logic        is_lo;
  logic        is_up;
  logic [3:0]  hv;
  logic        dotted;
  logic [20:0] hex_v;
  logic [12:0] dec_v;
  parse_st_t   n;

  assign is_dec = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_lo  = (char_code >= 8'h61) && (char_code <= 8'h66);
  assign is_up  = (char_code >= 8'h41) && (char_code <= 8'h46);
  assign dotted = (st.text_form == FormDotted) || st.in_dotted_tail;

  always_comb begin
    if (is_dec) begin
      hv = char_code[3:0];
    end else begin
      hv = 4'(char_code[2:0] + 3'd1) + 4'd8;
    end
  end

  always_comb begin
    n     = st;
    hex_v = '0;
    dec_v = '0;
    if (!st.error_flag) begin
      if (is_dec || is_lo || is_up) begin
        if ((st.sep_state == SepLeadColon) || (dotted && !is_dec)) begin
          n.error_flag = 1'b1;
        end else if ((st.sep_state != SepToken) && !dotted &&
                     (st.groups_done >= 4'(GroupCount))) begin
          n.error_flag = 1'b1;
        end else begin
          if (st.sep_state != SepToken) begin
            n.hex_accum        = '0;
            n.dec_accum        = '0;
            n.digit_count      = '0;
            n.hex_letter_seen  = 1'b0;
            n.first_digit_zero = (char_code == 8'h30);
          end
          if (!is_dec) begin
            n.hex_letter_seen = 1'b1;
          end
          hex_v = {n.hex_accum, 4'b0000} + 21'(hv);
          if (hex_v > 21'(HexMax)) begin
            n.hex_accum  = HexOver;
            n.error_flag = 1'b1;
          end else begin
            n.hex_accum = hex_v[16:0];
          end
          if (is_dec) begin
            dec_v = {n.dec_accum, 3'b000} + {3'b000, n.dec_accum, 1'b0} + 13'(hv);
            n.dec_accum = (dec_v > 13'(DecMax)) ? DecOver : dec_v[8:0];
          end
          if (n.digit_count != 2'd3) begin
            n.digit_count = n.digit_count + 2'd1;
          end
          n.sep_state = SepToken;
        end
      end else if (char_code == 8'h2E) begin
        if (st.sep_state != SepToken) begin
          n.error_flag = 1'b1;
        end else if ((st.text_form == FormColon) && !st.in_dotted_tail &&
                     ((st.groups_done > 4'd6) ||
                      (!st.gap_seen && (st.groups_done != 4'd6)))) begin
          n.error_flag = 1'b1;
        end else begin
          if (st.text_form == FormUndecided) begin
            n.text_form   = FormDotted;
            n.octet_index = '0;
            n.octet_store = '0;
          end else if ((st.text_form == FormColon) && !st.in_dotted_tail) begin
            n.in_dotted_tail = 1'b1;
            n.octet_index    = '0;
            n.octet_store    = '0;
          end
          if (n.octet_index >= 3'd3) begin
            n.error_flag = 1'b1;
          end else begin
            n             = take_octet(n);
            n.octet_index = n.octet_index + 3'd1;
            n.sep_state   = SepAfterDot;
          end
        end
      end else if (char_code == 8'h3A) begin
        if (dotted) begin
          n.error_flag = 1'b1;
        end else begin
          n.text_form = FormColon;
          unique case (st.sep_state)
            SepStart: n.sep_state = SepLeadColon;
            SepLeadColon: begin
              n.gap_seen     = 1'b1;
              n.gap_position = '0;
              n.sep_state    = SepAfterGap;
            end
            SepToken: begin
              n           = take_group(n);
              n.sep_state = SepAfterColon;
            end
            SepAfterColon: begin
              if (st.gap_seen) begin
                n.error_flag = 1'b1;
              end else begin
                n.gap_seen     = 1'b1;
                n.gap_position = st.groups_done;
                n.sep_state    = SepAfterGap;
              end
            end
            default: n.error_flag = 1'b1;
          endcase
        end
      end else begin
        n.error_flag = 1'b1;
      end
    end
  end

  assign st_next = n;

endmodule

FILE: design/ipa_finish.sv
// ----------------------------------------------------------------------------
// ipa_finish
// Closes the text: final checks and expansion of the gap into 128 bits.
// ----------------------------------------------------------------------------
module ipa_finish (
  input  ipa_pkg::parse_st_t st,
  output logic               valid_res,
  output logic [63:0]        addr_high,
  output logic [63:0]        addr_low,
  output logic               dotted_form
);
  import ipa_pkg::*;

  parse_st_t s;
  logic      ok;
  logic      is_dot;
  group_t [GroupCount-1:0] full;
  logic [4:0] p5;

  always_comb begin
    s      = st;
    ok     = !st.error_flag;
    is_dot = 1'b0;
    if (st.text_form == FormDotted) begin
      is_dot = 1'b1;
      if ((st.sep_state != SepToken) || (st.octet_index != 3'd3)) begin
        ok = 1'b0;
      end
      s = take_octet(s);
      if (s.error_flag) begin
        ok = 1'b0;
      end
    end else if (st.text_form != FormColon) begin
      ok = 1'b0;
    end else begin
      if (st.in_dotted_tail) begin
        if ((st.sep_state != SepToken) || (st.octet_index != 3'd3) ||
            (st.groups_done > 4'd6)) begin
          ok = 1'b0;
        end
        s = take_octet(s);
        if (s.error_flag) begin
          ok = 1'b0;
        end
        s.groups[s.groups_done[2:0]]        = s.octet_store[31:16];
        s.groups[s.groups_done[2:0] + 3'd1] = s.octet_store[15:0];
        s.groups_done = s.groups_done + 4'd2;
      end else if (st.sep_state == SepToken) begin
        s = take_group(s);
        if (s.error_flag) begin
          ok = 1'b0;
        end
      end else if (st.sep_state != SepAfterGap) begin
        ok = 1'b0;
      end
      if ((s.groups_done > 4'(GroupCount)) || (s.gap_position > s.groups_done)) begin
        ok = 1'b0;
      end
      if ((s.groups_done < 4'(GroupCount)) ? !s.gap_seen : s.gap_seen) begin
        ok = 1'b0;
      end
    end
  end

  // Groups before the gap keep their place, groups after it move to the end.
  always_comb begin
    p5 = '0;
    for (int p = 0; p < GroupCount; p++) begin
      p5 = 5'(p);
      if (p5 < {1'b0, s.gap_position}) begin
        full[p] = s.groups[p];
      end else if ((p5 + {1'b0, s.groups_done}) >=
                   (5'(GroupCount) + {1'b0, s.gap_position})) begin
        full[p] = s.groups[3'(p5 + {1'b0, s.groups_done})];
      end else begin
        full[p] = '0;
      end
    end
  end

  always_comb begin
    valid_res   = ok;
    dotted_form = ok && is_dot;
    addr_high   = '0;
    addr_low    = '0;
    if (ok) begin
      if (is_dot) begin
        addr_low = {16'h0000, 16'hFFFF, s.octet_store};
      end else begin
        addr_high = {full[0], full[1], full[2], full[3]};
        addr_low  = {full[4], full[5], full[6], full[7]};
      end
    end
  end

endmodule

FILE: design/ip_address_text_parser.sv
// ----------------------------------------------------------------------------
// ip_address_text_parser
// Parses IPv4 dotted and IPv6 colon text, one character per transfer.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and gives one result transfer for
// the character flagged as last, carrying the validity flag, the 128-bit
// address (IPv4 is returned mapped as ::ffff:a.b.c.d) and the dotted flag.
// Each character passes through an input register, one pass of next-state
// logic and, for the last character, the result register. The result
// register is loaded as the last character leaves the input register, and
// that move waits while the output stall holds back a result. The
// throughput is one character per cycle; the input stalls only when a
// character sits in the input register while a finished result is still
// held back by the output stall. After the last character all parser state
// returns to reset, so the next text may follow in the very next cycle.
module ip_address_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [63:0] addr_high,
  output logic [63:0] addr_low,
  output logic        dotted_form
);
  import ipa_pkg::*;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;

  // Parser state.
  parse_st_t  st;
  parse_st_t  st_next;

  logic        fin_valid;
  logic [63:0] fin_high;
  logic [63:0] fin_low;
  logic        fin_dotted;

  logic advance;
  logic take_in;

  // The held character moves on whenever the result register is free or
  // being emptied in this cycle.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign take_in  = in_valid && !in_stall;

  ipa_step u_step (
    .st        (st),
    .char_code (s1_char),
    .st_next   (st_next)
  );

  ipa_finish u_finish (
    .st          (st_next),
    .valid_res   (fin_valid),
    .addr_high   (fin_high),
    .addr_low    (fin_low),
    .dotted_form (fin_dotted)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (take_in) begin
      s1_char <= char_code;
      s1_last <= last_char;
    end
  end

  // Parser state returns to reset once the last character has been used.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= s1_last ? parse_st_t'('0) : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_last) begin
      valid_res   <= fin_valid;
      addr_high   <= fin_high;
      addr_low    <= fin_low;
      dotted_form <= fin_dotted;
    end
  end

endmodule

FILE: design/ipa_checker.sv
// ----------------------------------------------------------------------------
// ipa_checker
// Port-level checks of the IP address text parser.
// ----------------------------------------------------------------------------
module ipa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  char_code,
  input logic        last_char,
  input logic        out_valid,
  input logic        out_stall,
  input logic        valid_res,
  input logic [63:0] addr_high,
  input logic [63:0] addr_low,
  input logic        dotted_form
);

  // An invalid text always reports an all-zero address.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (addr_high == 64'h0 && addr_low == 64'h0 &&
                                   !dotted_form))
    else $error("invalid result carries a non-zero address");

  // A dotted result is valid and IPv4-mapped.
  a_dotted_mapped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dotted_form) |-> (valid_res && addr_high == 64'h0 &&
                                    addr_low[63:32] == 32'h0000FFFF))
    else $error("dotted result is not IPv4-mapped");

  // A result never appears in the first cycle after reset is released.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!rst, 1))
    else $error("result without reset release");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(addr_high) &&
                                  $stable(addr_low) && $stable(valid_res)))
    else $error("stalled result changed");

endmodule

bind ip_address_text_parser ipa_checker u_ipa_checker (.*);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IP address text parser.
// ----------------------------------------------------------------------------
// Address texts are built as character transfers and queued by the stimulus
// block. A clocked driver sends them in bursts with random gaps, and a
// clocked monitor compares each result transfer with the next expected
// address. The expected addresses come from a behavioural parser that runs
// over each character as it is driven.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ipa_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        dotted;
  } addr_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = 8'd0;
  logic        last_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        valid_res;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic        dotted_form;

  char_item_t   pending_chars[$];
  addr_result_t expected_addrs[$];
  int           error_count = 0;
  bit           stimulus_done = 1'b0;

  // Copy of the parser state that the predictor advances.
  logic [15:0] p_groups[8];
  logic [3:0]  p_groups_done;
  logic        p_gap_seen;
  logic [3:0]  p_gap_pos;
  logic [16:0] p_hex;
  logic [8:0]  p_dec;
  logic [1:0]  p_digits;
  logic        p_first_zero;
  logic        p_hex_letter;
  logic [1:0]  p_form;
  logic [2:0]  p_octet_idx;
  logic [31:0] p_octets;
  logic        p_tail;
  logic [2:0]  p_sep;
  logic        p_err;

  always #2 clk = ~clk;

  ip_address_text_parser dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .char_code(char_code), .last_char(last_char), .out_valid(out_valid),
    .out_stall(out_stall), .valid_res(valid_res), .addr_high(addr_high),
    .addr_low(addr_low), .dotted_form(dotted_form)
  );

  function automatic void clear_parser();
    foreach (p_groups[j]) p_groups[j] = 16'd0;
    p_groups_done = 4'd0;
    p_gap_seen = 1'b0;
    p_gap_pos = 4'd0;
    p_hex = 17'd0;
    p_dec = 9'd0;
    p_digits = 2'd0;
    p_first_zero = 1'b0;
    p_hex_letter = 1'b0;
    p_form = FormUndecided;
    p_octet_idx = 3'd0;
    p_octets = 32'd0;
    p_tail = 1'b0;
    p_sep = SepStart;
    p_err = 1'b0;
  endfunction

  // Folds the decimal accumulator into the IPv4 word, flagging bad octets.
  function automatic void close_octet();
    if (p_dec > DecMax || p_hex_letter || (p_first_zero && p_digits >= 2'd2) ||
        p_octet_idx > 3'd3) begin
      p_err = 1'b1;
    end else begin
      p_octets = p_octets | (32'(p_dec[7:0]) << ((3 - p_octet_idx) * 8));
    end
  endfunction

  function automatic void close_group();
    if (p_groups_done >= 4'd8 || p_hex > HexMax) begin
      p_err = 1'b1;
    end else begin
      p_groups[p_groups_done[2:0]] = p_hex[15:0];
      p_groups_done = p_groups_done + 4'd1;
    end
  endfunction

  function automatic void take_digit(logic [7:0] c, int unsigned hv, bit isdec);
    bit in_dotted;
    int unsigned v;
    in_dotted = (p_form == FormDotted) || p_tail;
    if (p_sep == SepLeadColon || (in_dotted && !isdec)) begin
      p_err = 1'b1;
      return;
    end
    if (p_sep != SepToken) begin
      if (!in_dotted && p_groups_done >= 4'd8) begin
        p_err = 1'b1;
        return;
      end
      p_hex = 17'd0;
      p_dec = 9'd0;
      p_digits = 2'd0;
      p_hex_letter = 1'b0;
      p_first_zero = (c == "0");
    end
    if (!isdec) p_hex_letter = 1'b1;
    v = p_hex * 16 + hv;
    if (v > 32'hFFFF) begin
      p_hex = HexOver;
      p_err = 1'b1;
    end else begin
      p_hex = 17'(v);
    end
    if (isdec) begin
      v = p_dec * 10 + hv;
      p_dec = (v > 255) ? DecOver : 9'(v);
    end
    if (p_digits < 2'd3) p_digits = p_digits + 2'd1;
    p_sep = SepToken;
  endfunction

  function automatic void take_dot();
    if (p_sep != SepToken) begin
      p_err = 1'b1;
      return;
    end
    if (p_form == FormUndecided) begin
      p_form = FormDotted;
      p_octet_idx = 3'd0;
      p_octets = 32'd0;
    end else if (p_form == FormColon && !p_tail) begin
      if (p_groups_done > 4'd6 || (!p_gap_seen && p_groups_done != 4'd6)) begin
        p_err = 1'b1;
        return;
      end
      p_tail = 1'b1;
      p_octet_idx = 3'd0;
      p_octets = 32'd0;
    end
    if (p_octet_idx >= 3'd3) begin
      p_err = 1'b1;
      return;
    end
    close_octet();
    p_octet_idx = p_octet_idx + 3'd1;
    p_sep = SepAfterDot;
  endfunction

  function automatic void take_colon();
    if (p_form == FormDotted || p_tail) begin
      p_err = 1'b1;
      return;
    end
    p_form = FormColon;
    case (p_sep)
      SepStart: p_sep = SepLeadColon;
      SepLeadColon: begin
        p_gap_seen = 1'b1;
        p_gap_pos = 4'd0;
        p_sep = SepAfterGap;
      end
      SepToken: begin
        close_group();
        p_sep = SepAfterColon;
      end
      SepAfterColon: begin
        if (p_gap_seen) begin
          p_err = 1'b1;
        end else begin
          p_gap_seen = 1'b1;
          p_gap_pos = p_groups_done;
          p_sep = SepAfterGap;
        end
      end
      default: p_err = 1'b1;
    endcase
  endfunction

  // Works out the address at the end of a text; all zero when it is invalid.
  function automatic addr_result_t close_text();
    addr_result_t r;
    logic [15:0] full[8];
    r = '0;
    if (p_err) return r;
    if (p_form == FormDotted) begin
      if (p_sep != SepToken || p_octet_idx != 3'd3) return r;
      close_octet();
      if (p_err) return r;
      r.ok = 1'b1;
      r.lo = {32'h0000FFFF, p_octets};
      r.dotted = 1'b1;
      return r;
    end
    if (p_form != FormColon) return r;
    if (p_tail) begin
      if (p_sep != SepToken || p_octet_idx != 3'd3 || p_groups_done > 4'd6) return r;
      close_octet();
      if (p_err) return r;
      p_groups[p_groups_done[2:0]] = p_octets[31:16];
      p_groups[p_groups_done[2:0] + 3'd1] = p_octets[15:0];
      p_groups_done = p_groups_done + 4'd2;
    end else if (p_sep == SepToken) begin
      close_group();
      if (p_err) return r;
    end else if (p_sep != SepAfterGap) begin
      return r;
    end
    if (p_groups_done > 4'd8 || p_gap_pos > p_groups_done) return r;
    if ((p_groups_done < 4'd8) ? !p_gap_seen : p_gap_seen) return r;
    foreach (full[j]) full[j] = 16'd0;
    for (int j = 0; j < p_groups_done; j++) begin
      if (j < p_gap_pos) full[j] = p_groups[j];
      else full[(j + 8 - p_groups_done) & 7] = p_groups[j];
    end
    r.ok = 1'b1;
    r.hi = {full[0], full[1], full[2], full[3]};
    r.lo = {full[4], full[5], full[6], full[7]};
    return r;
  endfunction

  function automatic void predict_char(char_item_t it);
    logic [7:0] c;
    c = it.code;
    if (!p_err) begin
      if (c >= "0" && c <= "9") take_digit(c, c - "0", 1'b1);
      else if (c >= "a" && c <= "f") take_digit(c, c - "a" + 10, 1'b0);
      else if (c >= "A" && c <= "F") take_digit(c, c - "A" + 10, 1'b0);
      else if (c == ".") take_dot();
      else if (c == ":") take_colon();
      else p_err = 1'b1;
    end
    if (it.last) begin
      expected_addrs.push_back(close_text());
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  // Queues a text as character transfers, the last one flagged.
  function automatic void queue_text(string s);
    for (int j = 0; j < s.len(); j++) begin
      pending_chars.push_back('{code: s[j], last: (j == s.len() - 1)});
    end
  endfunction

  function automatic string rand_octet();
    case ($urandom_range(0, 5))
      0: return "0";
      1: return "255";
      2: return $sformatf("%0d", $urandom_range(256, 999));
      3: return $sformatf("0%0d", $urandom_range(0, 99));
      default: return $sformatf("%0d", $urandom_range(0, 255));
    endcase
  endfunction

  function automatic string rand_group();
    string g;
    int n;
    n = $urandom_range(1, 5);
    g = "";
    for (int j = 0; j < n; j++) begin
      case ($urandom_range(0, 2))
        0: g = {g, string'(8'("0" + $urandom_range(0, 9)))};
        1: g = {g, string'(8'("a" + $urandom_range(0, 5)))};
        default: g = {g, string'(8'("A" + $urandom_range(0, 5)))};
      endcase
    end
    return g;
  endfunction

  function automatic string rand_dotted();
    return {rand_octet(), ".", rand_octet(), ".", rand_octet(), ".", rand_octet()};
  endfunction

  // A mostly well-formed IPv6 text: some groups, an optional gap and an
  // optional dotted tail.
  function automatic string rand_colon_text();
    string s;
    int ng, gap, tail;
    tail = ($urandom_range(0, 3) == 0);
    ng = $urandom_range(0, tail ? 6 : 8);
    gap = ($urandom_range(0, 2) != 0) ? $urandom_range(0, ng) : -1;
    s = "";
    for (int j = 0; j < ng; j++) begin
      if (j == gap) s = {s, "::"};
      else if (j > 0) s = {s, ":"};
      s = {s, rand_group()};
    end
    if (gap == ng) s = {s, "::"};
    if (tail) s = {s, (ng == 0 || gap == ng) ? "" : ":", rand_dotted()};
    if (s.len() == 0) s = "::";
    return s;
  endfunction

  // A text with one character replaced by a random code, or a stray colon
  // or dot added.
  function automatic string mangle(string s);
    int p;
    p = $urandom_range(0, s.len() - 1);
    case ($urandom_range(0, 2))
      0: s[p] = 8'($urandom_range(0, 255));
      1: s = {s.substr(0, p), ":", s.substr(p + 1, s.len() - 1)};
      default: s = {s.substr(0, p), ".", s.substr(p + 1, s.len() - 1)};
    endcase
    return s;
  endfunction

  // Driver: bursts of transfers with random gaps; the payload holds while
  // the block stalls.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          char_item_t it;
          it = pending_chars.pop_front();
          predict_char(it);
          in_valid <= 1'b1;
          char_code <= it.code;
          last_char <= it.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: long free stretches alternate with busy ones.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) out_stall <= 1'b0;
    else if (stall_phase[8]) out_stall <= ($urandom_range(0, 2) == 0);
    else out_stall <= 1'b0;
  end

  // Monitor: each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_addrs.size() == 0) begin
        report_mismatch("unexpected result", {63'd0, valid_res}, 64'd0);
      end else begin
        addr_result_t e;
        e = expected_addrs.pop_front();
        if (valid_res !== e.ok) report_mismatch("valid_res", 64'(valid_res), 64'(e.ok));
        if (addr_high !== e.hi) report_mismatch("addr_high", addr_high, e.hi);
        if (addr_low !== e.lo) report_mismatch("addr_low", addr_low, e.lo);
        if (dotted_form !== e.dotted)
          report_mismatch("dotted_form", 64'(dotted_form), 64'(e.dotted));
      end
    end
  end

  initial begin
    string s;
    clear_parser();
    // Directed texts: the extremes and each rejection rule.
    queue_text("0.0.0.0");
    queue_text("255.255.255.255");
    queue_text("256.1.1.1");
    queue_text("01.2.3.4");
    queue_text("1.2.3");
    queue_text("1.2.3.4.5");
    queue_text("1.a.3.4");
    queue_text("1234");
    queue_text("1:2:3:4:5:6:7:8");
    queue_text("FFFF:ffff:0:0:0:0:0:0001");
    queue_text("1:2:3:4:5:6:7:8:9");
    queue_text("10000::1");
    queue_text("::");
    queue_text("::1");
    queue_text("1::");
    queue_text("1::2::3");
    queue_text(":::");
    queue_text(":1::2");
    queue_text("1:2:");
    queue_text("1:2:3:4:5:6:1.2.3.4");
    queue_text("::ffff:10.0.0.1");
    queue_text("1:2:3:4:5:1.2.3.4");
    queue_text("1:2:3:4:5:6:7::1.2.3.4");
    queue_text("1:2:3:4::5:6:7:8");
    queue_text("1:2 3");
    // Random texts: mostly well-formed with random content.
    while (pending_chars.size() < 800) begin
      case ($urandom_range(0, 9))
        0, 1, 2: s = rand_dotted();
        3, 4, 5, 6: s = rand_colon_text();
        7: s = mangle(rand_colon_text());
        8: s = mangle(rand_dotted());
        default: begin
          s = "";
          repeat ($urandom_range(1, 4)) s = {s, string'(8'($urandom_range(1, 255)))};
        end
      endcase
      queue_text(s);
    end
    // A lone character code 0, which the noise texts never use, ends the stimulus.
    pending_chars.push_back('{code: 8'd0, last: 1'b1});
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_chars.size() == 0 && !in_valid);
    wait (expected_addrs.size() == 0);
    repeat (20) @(posedge clk);
    stimulus_done = 1'b1;
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin
    #2000000;
    if (!stimulus_done) begin
      $display("FAILURE");
      $finish;
    end
  end
endmodule
